@@ rtl/fvt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvt_pkg
// Shared types and constants for the frustum visibility test block.
// ----------------------------------------------------------------------------
package fvt_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = 3;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = COORD_WIDTH + DIFF_W;
    localparam int DIST_W      = PROD_W + 2;

    typedef enum logic [2:0] {
        KIND_LOAD_NORMAL = 3'd0,
        KIND_LOAD_ANCHOR = 3'd1,
        KIND_POINT       = 3'd2,
        KIND_SPHERE      = 3'd3,
        KIND_BOX         = 3'd4
    } kind_t;

    localparam logic [1:0] TEST_POINT  = 2'd0;
    localparam logic [1:0] TEST_SPHERE = 2'd1;
    localparam logic [1:0] TEST_BOX    = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         plane_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [30:0]        sphere_radius;
        logic               last_corner;
    } fvt_in_t;

    typedef struct packed {
        logic       visible;
        logic [1:0] test_type;
    } fvt_out_t;

    // classified query handed from front to back
    typedef struct packed {
        logic [1:0]                    op;      // test_type code
        logic                          last;
        logic [30:0]                   radius;
        logic signed [COORD_WIDTH-1:0] qx;
        logic signed [COORD_WIDTH-1:0] qy;
        logic signed [COORD_WIDTH-1:0] qz;
    } fvt_query_t;

endpackage

@@ rtl/fvt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvt_front
// Accepts items, applies plane loads, forwards tests as classified queries.
// ----------------------------------------------------------------------------
module fvt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fvt_pkg::fvt_in_t    s_data,
    output logic                q_valid,
    input  logic                q_ready,
    output fvt_pkg::fvt_query_t q_data,
    input  logic                plane_busy,
    output logic [fvt_pkg::PLANE_COUNT-1:0] nw_en,
    output logic [fvt_pkg::PLANE_COUNT-1:0] aw_en,
    output logic signed [fvt_pkg::COORD_WIDTH-1:0] w_x,
    output logic signed [fvt_pkg::COORD_WIDTH-1:0] w_y,
    output logic signed [fvt_pkg::COORD_WIDTH-1:0] w_z
);
    import fvt_pkg::*;

    logic is_test;
    logic is_load;
    logic accept;

    always_comb begin
        is_test = (s_data.kind == KIND_POINT) || (s_data.kind == KIND_SPHERE)
               || (s_data.kind == KIND_BOX);
        is_load = (s_data.kind == KIND_LOAD_NORMAL) || (s_data.kind == KIND_LOAD_ANCHOR);
        // tests wait for queue space; loads wait until earlier tests have read the planes
        s_ready = is_test ? q_ready : (!is_load || !plane_busy);
        accept  = s_valid && s_ready;
        q_valid = s_valid && is_test;
        w_x = s_data.coord_x[COORD_WIDTH-1:0];
        w_y = s_data.coord_y[COORD_WIDTH-1:0];
        w_z = s_data.coord_z[COORD_WIDTH-1:0];
        for (int i = 0; i < PLANE_COUNT; i++) begin
            nw_en[i] = accept && (s_data.kind == KIND_LOAD_NORMAL)
                    && (s_data.plane_index == IDX_W'(i));
            aw_en[i] = accept && (s_data.kind == KIND_LOAD_ANCHOR)
                    && (s_data.plane_index == IDX_W'(i));
        end
        q_data.op     = (s_data.kind == KIND_POINT)  ? TEST_POINT :
                        (s_data.kind == KIND_SPHERE) ? TEST_SPHERE : TEST_BOX;
        q_data.last   = s_data.last_corner;
        q_data.radius = s_data.sphere_radius;
        q_data.qx     = s_data.coord_x[COORD_WIDTH-1:0];
        q_data.qy     = s_data.coord_y[COORD_WIDTH-1:0];
        q_data.qz     = s_data.coord_z[COORD_WIDTH-1:0];
    end

`ifndef SYNTHESIS
    a_load_no_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (|nw_en || |aw_en) |-> !q_valid) else $error("load pushed a query");
    a_onehot_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({nw_en, aw_en})) else $error("multiple plane writes");
    a_test_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (s_ready == q_ready)) else $error("test ready mismatch");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (|nw_en || |aw_en) |-> !plane_busy) else $error("load while planes in use");
`endif
endmodule

@@ rtl/fvt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvt_queue
// Two-entry queue decoupling the front from the evaluation pipeline.
// ----------------------------------------------------------------------------
module fvt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fvt_pkg::fvt_query_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fvt_pkg::fvt_query_t out_data
);
    import fvt_pkg::*;

    fvt_query_t mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    always_comb begin
        in_ready  = (cnt_reg != 2'd2);
        out_valid = (cnt_reg != 2'd0);
        out_data  = mem_reg[rp_reg];
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;
        wp_next   = wp_reg ^ push;
        rp_next   = rp_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> (wp_reg != rp_reg)) else $error("pointer mismatch");
    a_empty_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> (wp_reg == rp_reg)) else $error("empty pointer mismatch");
`endif
endmodule

@@ rtl/fvt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvt_back
// Plane store and three-stage distance pipeline with result register.
// ----------------------------------------------------------------------------
module fvt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [fvt_pkg::PLANE_COUNT-1:0] nw_en,
    input  logic [fvt_pkg::PLANE_COUNT-1:0] aw_en,
    input  logic signed [fvt_pkg::COORD_WIDTH-1:0] w_x,
    input  logic signed [fvt_pkg::COORD_WIDTH-1:0] w_y,
    input  logic signed [fvt_pkg::COORD_WIDTH-1:0] w_z,
    input  logic                q_valid,
    output logic                q_ready,
    input  fvt_pkg::fvt_query_t q_data,
    output logic                plane_rd_pend,
    output logic                m_valid,
    input  logic                m_ready,
    output fvt_pkg::fvt_out_t   m_data
);
    import fvt_pkg::*;

    logic signed [COORD_WIDTH-1:0] nx_reg [PLANE_COUNT], ny_reg [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] nz_reg [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] ax_reg [PLANE_COUNT], ay_reg [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] az_reg [PLANE_COUNT];

    // stage 1: differences; stage 2: products; stage 3: sum and compare
    logic                      v1_reg, v2_reg, v3_reg;
    fvt_query_t                s1_reg, s2_reg;
    logic [1:0]                op3_reg;
    logic                      last3_reg;
    logic signed [DIFF_W-1:0]  dx_reg [PLANE_COUNT], dy_reg [PLANE_COUNT];
    logic signed [DIFF_W-1:0]  dz_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0]  px_reg [PLANE_COUNT], py_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0]  pz_reg [PLANE_COUNT];
    logic [PLANE_COUNT-1:0]    neg3_reg, pos3_reg;
    logic [PLANE_COUNT-1:0]    seen_reg, seen_next;
    logic                      ov_reg, ov_next;
    fvt_out_t                  od_reg, od_next;
    logic                      adv3, adv2, adv1, adv0, emit;
    logic signed [DIST_W-1:0]  dsum [PLANE_COUNT];
    logic signed [DIST_W-1:0]  bias;
    logic [PLANE_COUNT-1:0]    neg_c, pos_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                nx_reg[i] <= '0; ny_reg[i] <= '0; nz_reg[i] <= '0;
                ax_reg[i] <= '0; ay_reg[i] <= '0; az_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if (nw_en[i]) begin
                    nx_reg[i] <= w_x; ny_reg[i] <= w_y; nz_reg[i] <= w_z;
                end
                if (aw_en[i]) begin
                    ax_reg[i] <= w_x; ay_reg[i] <= w_y; az_reg[i] <= w_z;
                end
            end
        end
    end

    always_comb begin
        emit  = v3_reg && (op3_reg != TEST_BOX || last3_reg);
        adv3  = v3_reg && (!emit || !ov_reg || m_ready);
        adv2  = v2_reg && (!v3_reg || adv3);
        adv1  = v1_reg && (!v2_reg || adv2);
        adv0  = !v1_reg || adv1;
        q_ready = adv0;
        // stage 1 still has to read the normals
        plane_rd_pend = v1_reg;
        bias = (s2_reg.op == TEST_SPHERE)
             ? DIST_W'({s2_reg.radius, {FRAC_BITS{1'b0}}}) : '0;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            dsum[i] = DIST_W'(px_reg[i]) + DIST_W'(py_reg[i]) + DIST_W'(pz_reg[i])
                    + ((s2_reg.op == TEST_BOX) ? '0 : bias);
            neg_c[i] = dsum[i][DIST_W-1];
            pos_c[i] = !dsum[i][DIST_W-1] && (dsum[i] != '0);
        end
        seen_next = seen_reg;
        if (adv3 && op3_reg == TEST_BOX) begin
            seen_next = last3_reg ? '0 : (seen_reg | pos3_reg);
        end
        od_next = od_reg;
        ov_next = ov_reg && !m_ready;
        if (adv3 && emit) begin
            ov_next = 1'b1;
            od_next.test_type = op3_reg;
            od_next.visible   = (op3_reg == TEST_BOX) ? &(seen_reg | pos3_reg)
                                                      : ~|neg3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv0 && q_valid) begin
            s1_reg <= q_data;
            for (int i = 0; i < PLANE_COUNT; i++) begin
                dx_reg[i] <= DIFF_W'(ax_reg[i]) - DIFF_W'(q_data.qx);
                dy_reg[i] <= DIFF_W'(ay_reg[i]) - DIFF_W'(q_data.qy);
                dz_reg[i] <= DIFF_W'(az_reg[i]) - DIFF_W'(q_data.qz);
            end
        end
        if (adv1) begin
            s2_reg <= s1_reg;
            for (int i = 0; i < PLANE_COUNT; i++) begin
                px_reg[i] <= PROD_W'(nx_reg[i]) * PROD_W'(dx_reg[i]);
                py_reg[i] <= PROD_W'(ny_reg[i]) * PROD_W'(dy_reg[i]);
                pz_reg[i] <= PROD_W'(nz_reg[i]) * PROD_W'(dz_reg[i]);
            end
        end
        if (adv2) begin
            op3_reg   <= s2_reg.op;
            last3_reg <= s2_reg.last;
            neg3_reg  <= neg_c;
            pos3_reg  <= pos_c;
        end
        od_reg <= od_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ov_reg   <= 1'b0;
            seen_reg <= '0;
        end else begin
            if (adv0) v1_reg <= q_valid;
            v2_reg <= adv1 || (v2_reg && !adv2);
            if (adv2 || adv3 || !v3_reg) v3_reg <= adv2;
            ov_reg   <= ov_next;
            seen_reg <= seen_next;
        end
    end

    assign m_valid = ov_reg;
    assign m_data  = od_reg;

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");
    a_box_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv3 && op3_reg == TEST_BOX && last3_reg) |=> (seen_reg == '0))
        else $error("corner flags not cleared");
    a_type_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.test_type != 2'd3)) else $error("bad test type");
`endif
endmodule

@@ rtl/frustum_visibility_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_visibility_test
// Six-plane point, sphere and box visibility test.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless a test finds the queue full or a load is held
// off. A test goes through a two-entry queue into a three-stage pipeline
// (difference, multiply, sum and compare) that evaluates all planes in
// parallel, and tests are sustained at one per cycle while the result side
// keeps up. A plane load takes effect at its transfer, but it is held off while
// the queue or the first pipeline stage still holds a test that has to read the
// planes: a load right behind a test waits until that test has left both, and
// longer when results back up.
module frustum_visibility_test (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fvt_pkg::fvt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fvt_pkg::fvt_out_t m_data
);
    import fvt_pkg::*;

    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    fvt_query_t fq_data, qb_data;
    logic [PLANE_COUNT-1:0] nw_en, aw_en;
    logic signed [COORD_WIDTH-1:0] w_x, w_y, w_z;
    logic       plane_rd_pend, plane_busy;

    assign plane_busy = qb_valid || plane_rd_pend;

    fvt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data),
        .plane_busy(plane_busy),
        .nw_en(nw_en), .aw_en(aw_en), .w_x(w_x), .w_y(w_y), .w_z(w_z)
    );

    fvt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    fvt_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .nw_en(nw_en), .aw_en(aw_en), .w_x(w_x), .w_y(w_y), .w_z(w_z),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .plane_rd_pend(plane_rd_pend),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
